// ----- rtl/core/midi_solenoid_driver_with_timeout_defines.svh -----
// Assertion macros shared by the solenoid driver RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef MIDI_SOLENOID_DRIVER_WITH_TIMEOUT_DEFINES_SVH
`define MIDI_SOLENOID_DRIVER_WITH_TIMEOUT_DEFINES_SVH
`ifndef SYNTHESIS
`define MSD_ASSERT_SEQ(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MSD_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`else
`define MSD_ASSERT_SEQ(lbl, prop, msg)
`define MSD_ASSERT_ALWAYS(lbl, expr, msg)
`endif
`endif

// ----- rtl/core/msd_pkg.sv -----
package msd_pkg;

  // Default sizing
  localparam int MSD_CHANNELS   = 16;
  localparam int MSD_TIMER_BITS = 16;

  // Fixed field widths
  localparam int MSD_LINES     = 16;
  localparam int MSD_LINE_W    = 4;
  localparam int MSD_ORDER_W   = 64;
  localparam int MSD_NOTE_W    = 7;
  localparam int MSD_REQ_W     = 2;
  localparam int MSD_MAXON_W   = 16;
  localparam int MSD_DUTY_W    = 8;
  localparam int MSD_COUNT_W   = 5;
  localparam int MSD_CFG_IDX_W = 3;

  // Folding and blower constants
  localparam int MSD_FOLD_SPAN  = 12;
  localparam int MSD_FOLD_LO    = 16;
  localparam int MSD_FAN_SHIFT  = 4;
  localparam logic [MSD_DUTY_W-1:0] MSD_DUTY_AT_RESET = 8'd128;

  typedef logic [MSD_REQ_W-1:0]     req_t;
  typedef logic [MSD_CFG_IDX_W-1:0] cfg_idx_t;

  // Request codes
  localparam req_t REQ_NOTE_ON  = 2'd0;
  localparam req_t REQ_NOTE_OFF = 2'd1;
  localparam req_t REQ_TICK     = 2'd2;

  // Configuration register indexes
  localparam cfg_idx_t CFG_BASE_NOTE  = 3'd0;
  localparam cfg_idx_t CFG_FOLD_EN    = 3'd1;
  localparam cfg_idx_t CFG_MAX_ON_MS  = 3'd2;
  localparam cfg_idx_t CFG_FAN_MIN    = 3'd3;
  localparam cfg_idx_t CFG_FAN_MAX    = 3'd4;
  localparam cfg_idx_t CFG_LINE_ORDER = 3'd5;

  // Configuration reset values
  localparam logic [MSD_NOTE_W-1:0]  RST_BASE_NOTE  = 7'd60;
  localparam logic                   RST_FOLD_EN    = 1'b0;
  localparam logic [MSD_MAXON_W-1:0] RST_MAX_ON_MS  = 16'd5000;
  localparam logic [MSD_DUTY_W-1:0]  RST_FAN_MIN    = 8'd80;
  localparam logic [MSD_DUTY_W-1:0]  RST_FAN_MAX    = 8'd255;
  localparam logic [MSD_ORDER_W-1:0] RST_LINE_ORDER = 64'hFEDC_BA98_7654_3210;

endpackage

// ----- rtl/core/msd_in_if.sv -----
interface msd_in_if
  import msd_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [MSD_REQ_W-1:0]  req_type;
  logic [MSD_NOTE_W-1:0] note;

  modport source (output valid, output req_type, output note, input ready);
  modport sink   (input valid, input req_type, input note, output ready);
endinterface

// ----- rtl/core/msd_out_if.sv -----
interface msd_out_if
  import msd_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic [MSD_LINES-1:0]   drive_lines;
  logic [MSD_DUTY_W-1:0]  fan_duty;
  logic [MSD_COUNT_W-1:0] active_channels;

  modport source (output valid, output drive_lines, output fan_duty,
                  output active_channels, input ready);
  modport sink   (input valid, input drive_lines, input fan_duty,
                  input active_channels, output ready);
endinterface

// ----- rtl/core/msd_cfg_if.sv -----
interface msd_cfg_if
  import msd_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [MSD_CFG_IDX_W-1:0] index;
  logic [MSD_ORDER_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/midi_solenoid_driver_with_timeout.sv -----
// MIDI solenoid driver: each word on in_ch is a note-on, note-off or 1 ms tick and
// yields exactly one result word on out_ch with the line levels, blower duty and
// number of held channels after that word is applied. A note-on or note-off passes
// through the map and apply states, and also through the blower multiply and the
// sum when it changes a hold; a tick walks the channel timers one per cycle with a
// single saturating incrementer and limit comparator. in_ch is not ready until the
// result has moved into the output register, which may still wait on out_ch while
// the next word is accepted. Configuration writes are always accepted and must be
// made while no word is in progress.
`include "midi_solenoid_driver_with_timeout_defines.svh"

module midi_solenoid_driver_with_timeout
  import msd_pkg::*;
#(
  parameter int CHANNELS   = MSD_CHANNELS,
  parameter int TIMER_BITS = MSD_TIMER_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  msd_in_if.sink    in_ch,
  msd_out_if.source out_ch,
  msd_cfg_if.sink   cfg_ch
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CMP_W = (TIMER_BITS > MSD_MAXON_W) ? TIMER_BITS : MSD_MAXON_W;
  localparam int LB_W  = $clog2(MSD_ORDER_W);
  localparam int PRD_W = MSD_COUNT_W + MSD_DUTY_W - 1;
  localparam logic [CH_W-1:0] SCAN_LAST = CH_W'(CHANNELS - 1);

  // Sequencer codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAP   = 3'd1;
  localparam logic [2:0] ST_APPLY = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_SUM   = 3'd4;
  localparam logic [2:0] ST_SCAN  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  // Configuration registers
  logic [MSD_NOTE_W-1:0]  base_note_r;
  logic                   fold_en_r;
  logic [MSD_MAXON_W-1:0] max_on_ms_r;
  logic [MSD_DUTY_W-1:0]  fan_min_r;
  logic [MSD_DUTY_W-1:0]  fan_max_r;
  logic [MSD_ORDER_W-1:0] line_order_r;

  // Control state
  logic [2:0]             state_r, state_nxt;
  logic [CHANNELS-1:0]    held_r, held_nxt;
  logic [CHANNELS-1:0]    armed_r, armed_nxt;
  logic [MSD_COUNT_W-1:0] held_count_r, held_count_nxt;
  logic [MSD_LINES-1:0]   line_r, line_nxt;
  logic [MSD_DUTY_W-1:0]  blower_r, blower_nxt;
  logic [CH_W-1:0]        scan_r, scan_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // Per-word working registers
  logic [MSD_REQ_W-1:0]   req_r;
  logic [MSD_NOTE_W-1:0]  note_r;
  logic [CH_W-1:0]        ch_r;
  logic                   hit_r;
  logic [PRD_W-1:0]       prod_r;
  logic [MSD_LINES-1:0]   out_lines_r;
  logic [MSD_DUTY_W-1:0]  out_duty_r;
  logic [MSD_COUNT_W-1:0] out_count_r;

  // Channel timers
  logic [TIMER_BITS-1:0]  elapsed_r [CHANNELS];

  logic                   in_acc;
  logic                   out_load;
  logic signed [8:0]      n_raw, n_fold1, n_fold2, b_s, idx_s;
  logic                   map_hit;
  logic [CH_W-1:0]        sel_ch;
  logic [LB_W-1:0]        line_base;
  logic [MSD_LINE_W-1:0]  line_sel;
  logic [MSD_LINES-1:0]   line_mask;
  logic [MSD_DUTY_W-1:0]  fan_mag;
  logic                   fan_neg;
  logic [TIMER_BITS-1:0]  el_cur, el_inc;
  logic                   el_we;
  logic [CH_W-1:0]        el_addr;
  logic [TIMER_BITS-1:0]  el_wdata;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_load     = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid           = out_valid_r;
  assign out_ch.drive_lines     = out_lines_r;
  assign out_ch.fan_duty        = out_duty_r;
  assign out_ch.active_channels = out_count_r;

  // Fold the note by an octave, then map it onto a channel
  always_comb begin
    n_raw   = $signed({2'b00, note_r});
    b_s     = $signed({2'b00, base_note_r});
    n_fold1 = n_raw;
    n_fold2 = n_raw;
    if (fold_en_r) begin
      if ((n_raw >= b_s + 9'sd16) && (n_raw <= b_s + 9'sd28)) begin
        n_fold1 = n_raw - 9'(MSD_FOLD_SPAN);
      end
      n_fold2 = n_fold1;
      if (n_fold1 <= b_s - 9'(MSD_FOLD_SPAN)) begin
        n_fold2 = n_fold1 + 9'(MSD_FOLD_SPAN);
      end
    end
    idx_s   = n_fold2 - b_s;
    map_hit = (idx_s >= 9'sd0) && (idx_s < $signed(9'(CHANNELS)));
  end

  // Pick the physical line of the channel in hand
  assign sel_ch    = (state_r == ST_SCAN) ? scan_r : ch_r;
  assign line_base = LB_W'(sel_ch) * LB_W'(MSD_LINE_W);
  assign line_sel  = line_order_r[line_base +: MSD_LINE_W];
  assign line_mask = MSD_LINES'(1) << line_sel;

  // Blower slope magnitude and direction
  assign fan_neg = (fan_max_r < fan_min_r);
  assign fan_mag = fan_neg ? (fan_min_r - fan_max_r) : (fan_max_r - fan_min_r);

  // Shared timer unit: saturating increment of the scanned channel
  assign el_cur = elapsed_r[scan_r];
  assign el_inc = (el_cur != {TIMER_BITS{1'b1}}) ? (el_cur + 1'b1) : el_cur;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    held_nxt       = held_r;
    armed_nxt      = armed_r;
    held_count_nxt = held_count_r;
    line_nxt       = line_r;
    blower_nxt     = blower_r;
    scan_nxt       = scan_r;
    out_valid_nxt  = out_valid_r;
    el_we          = 1'b0;
    el_addr        = ch_r;
    el_wdata       = '0;

    // Drop the output word once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          scan_nxt = '0;
          if ((in_ch.req_type == REQ_NOTE_ON) || (in_ch.req_type == REQ_NOTE_OFF)) begin
            state_nxt = ST_MAP;
          end else if (in_ch.req_type == REQ_TICK) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_MAP: begin
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        state_nxt = ST_DONE;
        if (hit_r) begin
          if ((req_r == REQ_NOTE_ON) && !held_r[ch_r]) begin
            held_nxt[ch_r]  = 1'b1;
            armed_nxt[ch_r] = 1'b1;
            el_we           = 1'b1;
            held_count_nxt  = held_count_r + 1'b1;
            line_nxt        = line_r | line_mask;
            state_nxt       = ST_MUL;
          end else if ((req_r == REQ_NOTE_OFF) && held_r[ch_r]) begin
            held_nxt[ch_r]  = 1'b0;
            held_count_nxt  = held_count_r - 1'b1;
            line_nxt        = line_r & ~line_mask;
            state_nxt       = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        if (fan_neg) begin
          blower_nxt = fan_min_r - prod_r[MSD_FAN_SHIFT +: MSD_DUTY_W];
        end else begin
          blower_nxt = fan_min_r + prod_r[MSD_FAN_SHIFT +: MSD_DUTY_W];
        end
        state_nxt = ST_DONE;
      end
      ST_SCAN: begin
        // Advance one armed timer and retire it past the limit while any channel is held
        if (armed_r[scan_r]) begin
          el_we    = 1'b1;
          el_addr  = scan_r;
          el_wdata = el_inc;
          if ((held_count_r != '0) && (CMP_W'(el_inc) > CMP_W'(max_on_ms_r))) begin
            armed_nxt[scan_r] = 1'b0;
            line_nxt          = line_r & ~line_mask;
          end
        end
        if (scan_r == SCAN_LAST) begin
          state_nxt = ST_DONE;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      held_r       <= '0;
      armed_r      <= '0;
      held_count_r <= '0;
      line_r       <= '0;
      blower_r     <= MSD_DUTY_AT_RESET;
      scan_r       <= '0;
      out_valid_r  <= 1'b0;
      base_note_r  <= RST_BASE_NOTE;
      fold_en_r    <= RST_FOLD_EN;
      max_on_ms_r  <= RST_MAX_ON_MS;
      fan_min_r    <= RST_FAN_MIN;
      fan_max_r    <= RST_FAN_MAX;
      line_order_r <= RST_LINE_ORDER;
    end else begin
      state_r      <= state_nxt;
      held_r       <= held_nxt;
      armed_r      <= armed_nxt;
      held_count_r <= held_count_nxt;
      line_r       <= line_nxt;
      blower_r     <= blower_nxt;
      scan_r       <= scan_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_BASE_NOTE:  base_note_r  <= cfg_ch.data[MSD_NOTE_W-1:0];
          CFG_FOLD_EN:    fold_en_r    <= cfg_ch.data[0];
          CFG_MAX_ON_MS:  max_on_ms_r  <= cfg_ch.data[MSD_MAXON_W-1:0];
          CFG_FAN_MIN:    fan_min_r    <= cfg_ch.data[MSD_DUTY_W-1:0];
          CFG_FAN_MAX:    fan_max_r    <= cfg_ch.data[MSD_DUTY_W-1:0];
          CFG_LINE_ORDER: line_order_r <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  // Working registers and output word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r  <= in_ch.req_type;
      note_r <= in_ch.note;
    end
    if (state_r == ST_MAP) begin
      ch_r  <= idx_s[CH_W-1:0];
      hit_r <= map_hit;
    end
    if (state_r == ST_MUL) begin
      prod_r <= PRD_W'(held_count_r) * PRD_W'(fan_mag);
    end
    if (out_load) begin
      out_lines_r <= line_r;
      out_duty_r  <= blower_r;
      out_count_r <= held_count_r;
    end
  end

  // Timer store: cleared on arm, bumped during a scan
  always_ff @(posedge clk) begin
    if (el_we) begin
      elapsed_r[el_addr] <= el_wdata;
    end
  end

  `MSD_ASSERT_SEQ(a_busy_after_accept, (in_ch.valid && in_ch.ready) |=> (state_r != ST_IDLE), "word accepted but sequencer stayed idle")
  `MSD_ASSERT_ALWAYS(a_count_matches, held_count_r == MSD_COUNT_W'($countones(held_r)), "held count out of step with held channels")
  `MSD_ASSERT_SEQ(a_scan_steps, (state_r == ST_SCAN && scan_r != SCAN_LAST) |=> (scan_r == CH_W'($past(scan_r) + 1'b1)), "timer scan skipped a channel")
  `MSD_ASSERT_SEQ(a_out_from_done, $rose(out_valid_r) |-> ($past(state_r) == ST_DONE), "result offered without finishing a word")

endmodule

// ----- tb/tb_midi_solenoid_driver_with_timeout.sv -----
module tb_midi_solenoid_driver_with_timeout
  import msd_pkg::*;
  ();

  localparam int IDLE_LIMIT = 1000;
  localparam int PHASES     = 8;
  localparam int PHASE_WORDS = 106;

  typedef struct packed {
    logic [MSD_LINES-1:0]   drive_lines;
    logic [MSD_DUTY_W-1:0]  fan_duty;
    logic [MSD_COUNT_W-1:0] active_channels;
  } solenoid_state_t;

  typedef struct packed {
    logic                   is_reg;
    cfg_idx_t               reg_idx;
    logic [MSD_ORDER_W-1:0] reg_data;
    req_t                   req;
    logic [MSD_NOTE_W-1:0]  note;
    logic                   typed;
    solenoid_state_t        want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;

  msd_in_if  in_bus ();
  msd_out_if out_bus ();
  msd_cfg_if cfg_bus ();

  midi_solenoid_driver_with_timeout DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always #2 clk = ~clk;

  // Register copy held by the predictor
  logic [MSD_NOTE_W-1:0]  cur_base;
  logic                   cur_fold;
  logic [MSD_MAXON_W-1:0] cur_limit;
  logic [MSD_DUTY_W-1:0]  cur_fan_lo;
  logic [MSD_DUTY_W-1:0]  cur_fan_hi;
  logic [MSD_ORDER_W-1:0] cur_order;

  // Channel state held by the predictor
  logic                      held_ch    [MSD_CHANNELS];
  logic                      armed_ch   [MSD_CHANNELS];
  logic [MSD_TIMER_BITS-1:0] elapsed_ms [MSD_CHANNELS];
  int                        held_total;
  logic [MSD_LINES-1:0]      line_mask;
  logic [MSD_DUTY_W-1:0]     duty_now;

  solenoid_state_t pending_states[$];
  script_row_t     script[$];
  int              fault_count = 0;
  int              quiet_cycles = 0;
  logic            steady = 1'b0;

  task automatic flag_fault(string msg);
    fault_count++;
    if (fault_count <= 10) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Map a note to a channel, folding by an octave where enabled; -1 for none
  function automatic int channel_of(logic [MSD_NOTE_W-1:0] n_in);
    int n;
    int b;
    n = int'(n_in);
    b = int'(cur_base);
    if (cur_fold) begin
      if (n >= b + MSD_FOLD_LO && n <= b + MSD_FOLD_LO + MSD_FOLD_SPAN) n -= MSD_FOLD_SPAN;
      if (n <= b - MSD_FOLD_SPAN) n += MSD_FOLD_SPAN;
    end
    if (n - b < 0 || n - b >= MSD_CHANNELS) return -1;
    return n - b;
  endfunction

  function automatic logic [MSD_LINES-1:0] line_of(int ch);
    logic [MSD_LINES-1:0] one_hot;
    one_hot = '0;
    one_hot[cur_order[MSD_LINE_W*ch +: MSD_LINE_W]] = 1'b1;
    return one_hot;
  endfunction

  // Blower duty for a held count; falls toward fan_max when it is below fan_min
  function automatic logic [MSD_DUTY_W-1:0] blower_for(int count);
    int diff;
    int step;
    diff = int'(cur_fan_hi) - int'(cur_fan_lo);
    if (diff >= 0) step = (count * diff) / (1 << MSD_FAN_SHIFT);
    else step = -((count * -diff) / (1 << MSD_FAN_SHIFT));
    return MSD_DUTY_W'(int'(cur_fan_lo) + step);
  endfunction

  // Apply one word to the predicted state and return the levels it leaves
  function automatic solenoid_state_t advance_solenoids(req_t r, logic [MSD_NOTE_W-1:0] n);
    int ch;
    ch = channel_of(n);
    case (r)
      REQ_NOTE_ON: begin
        if (ch >= 0 && !held_ch[ch]) begin
          held_ch[ch]    = 1'b1;
          armed_ch[ch]   = 1'b1;
          elapsed_ms[ch] = '0;
          held_total++;
          line_mask |= line_of(ch);
          duty_now = blower_for(held_total);
        end
      end
      REQ_NOTE_OFF: begin
        if (ch >= 0 && held_ch[ch]) begin
          held_ch[ch] = 1'b0;
          held_total--;
          line_mask &= ~line_of(ch);
          duty_now = blower_for(held_total);
        end
      end
      REQ_TICK: begin
        for (int i = 0; i < MSD_CHANNELS; i++)
          if (armed_ch[i] && elapsed_ms[i] != '1) elapsed_ms[i]++;
        // time out only while something is held
        if (held_total != 0) begin
          for (int i = 0; i < MSD_CHANNELS; i++) begin
            if (armed_ch[i] && elapsed_ms[i] > cur_limit) begin
              line_mask &= ~line_of(i);
              armed_ch[i] = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    return {line_mask, duty_now, MSD_COUNT_W'(held_total)};
  endfunction

  function automatic script_row_t item_row(req_t r, int n);
    script_row_t row;
    row = '0;
    row.req  = r;
    row.note = MSD_NOTE_W'(n);
    return row;
  endfunction

  function automatic script_row_t known_row(req_t r, int n, logic [MSD_LINES-1:0] lines,
                                            logic [MSD_DUTY_W-1:0] duty,
                                            logic [MSD_COUNT_W-1:0] held);
    script_row_t row;
    row = item_row(r, n);
    row.typed = 1'b1;
    row.want  = {lines, duty, held};
    return row;
  endfunction

  function automatic script_row_t reg_row(cfg_idx_t idx, logic [MSD_ORDER_W-1:0] val);
    script_row_t row;
    row = '0;
    row.is_reg   = 1'b1;
    row.reg_idx  = idx;
    row.reg_data = val;
    return row;
  endfunction

  // Offer one word after a random gap; predict its result once taken
  task automatic send_word(req_t r, logic [MSD_NOTE_W-1:0] n, logic typed,
                           solenoid_state_t want);
    int gap;
    solenoid_state_t model;
    gap = steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.req_type <= r;
    in_bus.note     <= n;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    model = advance_solenoids(r, n);
    pending_states.push_back(typed ? want : model);
  endtask

  // Write one register; valid is left high for a following write
  task automatic write_reg(cfg_idx_t idx, logic [MSD_ORDER_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    case (idx)
      CFG_BASE_NOTE:  cur_base   = val[MSD_NOTE_W-1:0];
      CFG_FOLD_EN:    cur_fold   = val[0];
      CFG_MAX_ON_MS:  cur_limit  = val[MSD_MAXON_W-1:0];
      CFG_FAN_MIN:    cur_fan_lo = val[MSD_DUTY_W-1:0];
      CFG_FAN_MAX:    cur_fan_hi = val[MSD_DUTY_W-1:0];
      CFG_LINE_ORDER: cur_order  = val;
      default: ;
    endcase
  endtask

  // Hold the sender until every result is back, then let the block settle
  task automatic hold_off(int settle);
    in_bus.valid <= 1'b0;
    while (pending_states.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Take results after random stalls and compare with the oldest prediction
  initial begin
    int stall;
    solenoid_state_t got;
    solenoid_state_t want;
    out_bus.ready = 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (out_bus.valid !== 1'b1);
      got = {out_bus.drive_lines, out_bus.fan_duty, out_bus.active_channels};
      if (pending_states.size() == 0) begin
        flag_fault($sformatf("result word lines %h duty %0d held %0d with none outstanding",
                             got.drive_lines, got.fan_duty, got.active_channels));
      end else begin
        want = pending_states.pop_front();
        if (got.drive_lines !== want.drive_lines || got.fan_duty !== want.fan_duty ||
            got.active_channels !== want.active_channels)
          flag_fault($sformatf("lines %h duty %0d held %0d, wanted lines %h duty %0d held %0d",
                               got.drive_lines, got.fan_duty, got.active_channels,
                               want.drive_lines, want.fan_duty, want.active_channels));
      end
    end
  end

  // Abort when no channel moves a word for too long
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic                   regs_open;
    int                     sel;
    int                     nv;
    int                     b;
    int                     lo;
    req_t                   r;
    logic [MSD_ORDER_W-1:0] order;
    logic [MSD_MAXON_W-1:0] limit;

    // Drive every input to a known level before the first edge
    rst_n           = 1'b0;
    in_bus.valid    = 1'b0;
    in_bus.req_type = REQ_TICK;
    in_bus.note     = '0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.index   = CFG_BASE_NOTE;
    cfg_bus.data    = '0;
    regs_open       = 1'b0;

    cur_base   = RST_BASE_NOTE;
    cur_fold   = RST_FOLD_EN;
    cur_limit  = RST_MAX_ON_MS;
    cur_fan_lo = RST_FAN_MIN;
    cur_fan_hi = RST_FAN_MAX;
    cur_order  = RST_LINE_ORDER;
    for (int i = 0; i < MSD_CHANNELS; i++) begin
      held_ch[i]    = 1'b0;
      armed_ch[i]   = 1'b0;
      elapsed_ms[i] = '0;
    end
    held_total = 0;
    line_mask  = '0;
    duty_now   = MSD_DUTY_AT_RESET;

    // Reset values: idle requests, out-of-range notes, repeated note-on
    script.push_back(known_row(REQ_TICK,       0, 16'h0000, 8'd128, 5'd0));
    script.push_back(known_row(REQ_NOTE_OFF,  60, 16'h0000, 8'd128, 5'd0));
    script.push_back(known_row(REQ_NOTE_ON,    0, 16'h0000, 8'd128, 5'd0));
    script.push_back(known_row(REQ_NOTE_ON,  127, 16'h0000, 8'd128, 5'd0));
    script.push_back(known_row(REQ_NOTE_ON,   60, 16'h0001, 8'd90,  5'd1));
    script.push_back(known_row(REQ_NOTE_ON,   60, 16'h0001, 8'd90,  5'd1));
    script.push_back(known_row(REQ_NOTE_ON,   75, 16'h8001, 8'd101, 5'd2));
    script.push_back(item_row(REQ_NOTE_ON,  76));
    script.push_back(item_row(REQ_NOTE_OFF, 60));
    script.push_back(item_row(REQ_TICK,    127));
    // Lowest base, folding both ways, instant time-out, falling blower, one shared line
    script.push_back(reg_row(CFG_FOLD_EN,    64'd1));
    script.push_back(reg_row(CFG_BASE_NOTE,  64'd12));
    script.push_back(reg_row(CFG_MAX_ON_MS,  64'd0));
    script.push_back(reg_row(CFG_FAN_MIN,    64'd255));
    script.push_back(reg_row(CFG_FAN_MAX,    64'd0));
    script.push_back(reg_row(CFG_LINE_ORDER, 64'd0));
    script.push_back(item_row(REQ_NOTE_ON,  28));
    script.push_back(item_row(REQ_NOTE_ON,   0));
    script.push_back(item_row(REQ_NOTE_ON,  40));
    script.push_back(item_row(REQ_TICK,      0));
    script.push_back(item_row(REQ_NOTE_OFF, 28));
    script.push_back(item_row(REQ_NOTE_OFF,  0));
    // Highest base, longest limit, reversed line order
    script.push_back(reg_row(CFG_BASE_NOTE,  64'd111));
    script.push_back(reg_row(CFG_MAX_ON_MS,  64'd65535));
    script.push_back(reg_row(CFG_FAN_MIN,    64'd0));
    script.push_back(reg_row(CFG_FAN_MAX,    64'd255));
    script.push_back(reg_row(CFG_LINE_ORDER, 64'h0123_4567_89AB_CDEF));
    script.push_back(item_row(REQ_NOTE_ON,  127));
    script.push_back(item_row(REQ_NOTE_ON,   99));
    script.push_back(item_row(REQ_TICK,     127));
    script.push_back(item_row(REQ_NOTE_OFF, 127));
    script.push_back(item_row(REQ_NOTE_ON,  126));
    // Short limit: a released channel's timer still runs and times out
    script.push_back(reg_row(CFG_MAX_ON_MS,  64'd1));
    script.push_back(reg_row(CFG_FOLD_EN,    64'd0));
    script.push_back(item_row(REQ_TICK,       5));
    script.push_back(item_row(REQ_TICK,      64));
    script.push_back(item_row(REQ_NOTE_OFF, 111));
    script.push_back(item_row(REQ_TICK,     100));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed script
    foreach (script[i]) begin
      if (script[i].is_reg) begin
        if (!regs_open) hold_off(4);
        write_reg(script[i].reg_idx, script[i].reg_data);
        regs_open = 1'b1;
      end else begin
        if (regs_open) cfg_bus.valid <= 1'b0;
        regs_open = 1'b0;
        send_word(script[i].req, script[i].note, script[i].typed, script[i].want);
      end
    end

    // Random phases, each under a fresh register setting
    for (int phase = 0; phase < PHASES; phase++) begin
      hold_off(4);
      steady = (phase % 3 == 2);
      b = (phase == 0) ? 12 : (phase == 1) ? 111 : $urandom_range(12, 111);
      case ($urandom_range(0, 5))
        3:       limit = '0;
        4:       limit = '1;
        5:       limit = MSD_MAXON_W'($urandom_range(0, 65535));
        default: limit = MSD_MAXON_W'($urandom_range(0, 30));
      endcase
      case ($urandom_range(0, 3))
        0:       order = RST_LINE_ORDER;
        1:       order = {$urandom, $urandom};
        2:       order = {16{4'($urandom_range(0, 15))}};
        default: order = 64'h0123_4567_89AB_CDEF;
      endcase
      lo = (phase == 0) ? 0 : $urandom_range(0, 255);
      write_reg(CFG_BASE_NOTE,  MSD_ORDER_W'(b));
      write_reg(CFG_FOLD_EN,    MSD_ORDER_W'($urandom_range(0, 1)));
      write_reg(CFG_MAX_ON_MS,  MSD_ORDER_W'(limit));
      write_reg(CFG_FAN_MIN,    MSD_ORDER_W'(lo));
      if (phase == 0)
        write_reg(CFG_FAN_MAX, 64'd255);
      else if ($urandom_range(0, 4) == 0)
        write_reg(CFG_FAN_MAX, MSD_ORDER_W'($urandom_range(0, lo)));
      else
        write_reg(CFG_FAN_MAX, MSD_ORDER_W'($urandom_range(lo, 255)));
      write_reg(CFG_LINE_ORDER, order);
      cfg_bus.valid <= 1'b0;

      for (int k = 0; k < PHASE_WORDS; k++) begin
        // drain once mid-phase with the sender held back
        if (phase == 4 && k == PHASE_WORDS / 2) hold_off(4);
        sel = $urandom_range(0, 9);
        r = (sel < 4) ? REQ_NOTE_ON : (sel < 7) ? REQ_NOTE_OFF : REQ_TICK;
        // mostly notes on the channels, some in the fold bands, some anywhere
        case ($urandom_range(0, 9))
          6:       nv = b + MSD_FOLD_LO + $urandom_range(0, MSD_FOLD_SPAN);
          7:       nv = b - MSD_FOLD_SPAN - $urandom_range(0, MSD_FOLD_SPAN);
          8, 9:    nv = $urandom_range(0, 127);
          default: nv = b + $urandom_range(0, MSD_CHANNELS - 1);
        endcase
        if (nv < 0) nv = 0;
        if (nv > 127) nv = 127;
        send_word(r, MSD_NOTE_W'(nv), 1'b0, '0);
      end
    end

    hold_off(24);
    if (pending_states.size() != 0)
      flag_fault($sformatf("%0d results never arrived", pending_states.size()));
    if (fault_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
